// File: sv/sapc_pkg.sv
// shared types and constants for the source address packet counter
// no dependencies; imported by sapc_engine and the top level
`timescale 1ns / 1ps

package sapc_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);
  localparam int ADDR_W        = 32;
  localparam int COUNT_W       = 32;
  localparam int ENTRY_W       = 7;

  typedef logic [ADDR_W-1:0]  ip_addr_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [USED_W-1:0]  used_t;

  localparam count_t COUNT_MAX = '1;

  typedef enum logic [1:0] {
    STATUS_COUNTED = 2'd0,
    STATUS_CREATED = 2'd1,
    STATUS_DROPPED = 2'd2
  } status_e;

  // one stored slot: address and its packet count
  typedef struct packed {
    ip_addr_t addr;
    count_t   count;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    status_e              status;
    logic [ENTRY_W-1:0]   entry_index;
    count_t               packet_count;
  } result_t;

endpackage

// File: sv/sapc_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module sapc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/sapc_engine.sv
// search and update engine: walks the slot table, counts or creates an entry
// depends on sapc_pkg and sapc_ram
`timescale 1ns / 1ps

module sapc_engine
  import sapc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  ip_addr_t addr_i,
  output logic     ready_o,
  input  logic     out_free_i,
  output logic     res_valid_o,
  output result_t  res_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_MISS   = 3'b100
  } state_e;

  state_e   state_q, state_d;
  ip_addr_t addr_q, addr_d;
  idx_t     idx_q, idx_d;
  used_t    used_q, used_d;

  logic  re, we;
  idx_t  raddr, waddr;
  slot_t wdata, rdata;
  logic  hit, last;

  sapc_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // rdata holds the slot at idx_q while searching
  assign hit  = (rdata.addr == addr_q);
  assign last = ((USED_W'(idx_q) + USED_W'(1)) == used_q);

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    idx_d       = idx_q;
    used_d      = used_q;
    re          = 1'b0;
    raddr       = idx_q + idx_t'(1);
    we          = 1'b0;
    waddr       = idx_q;
    wdata.addr  = addr_q;
    wdata.count = count_t'(1);
    res_valid_o = 1'b0;
    res_o.status       = STATUS_DROPPED;
    res_o.entry_index  = '0;
    res_o.packet_count = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          addr_d = addr_i;
          if (used_q == '0) begin
            state_d = ST_MISS;
          end else begin
            re      = 1'b1;
            raddr   = '0;
            idx_d   = '0;
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          // hold here while the output register is still occupied
          if (out_free_i) begin
            we          = 1'b1;
            waddr       = idx_q;
            wdata.count = (rdata.count == COUNT_MAX) ? rdata.count
                                                     : rdata.count + count_t'(1);
            res_valid_o        = 1'b1;
            res_o.status       = STATUS_COUNTED;
            res_o.entry_index  = ENTRY_W'(idx_q);
            res_o.packet_count = wdata.count;
            state_d            = ST_IDLE;
          end
        end else if (last) begin
          state_d = ST_MISS;
        end else begin
          re    = 1'b1;
          raddr = idx_q + idx_t'(1);
          idx_d = idx_q + idx_t'(1);
        end
      end
      ST_MISS: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          if (used_q < USED_W'(TABLE_ENTRIES)) begin
            we                 = 1'b1;
            waddr              = used_q[IDX_W-1:0];
            wdata.count        = count_t'(1);
            used_d             = used_q + USED_W'(1);
            res_o.status       = STATUS_CREATED;
            res_o.entry_index  = ENTRY_W'(used_q[IDX_W-1:0]);
            res_o.packet_count = count_t'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    idx_q  <= idx_d;
  end

endmodule

// File: sv/source_address_packet_counter.sv
// top level of the per-source packet counter: stream ports and result register
// depends on sapc_pkg and sapc_engine
`timescale 1ns / 1ps

// channel   dir  signals                     fields (lowest bit first)
// -------   ---  --------------------------  ------------------------------------
// s_axis    in   tvalid, tready, tdata[31:0] source_address[31:0]
// m_axis    out  tvalid, tready, tdata[39:0] entry_index[6:0], packet_count[38:7]
//                tuser[1:0]                  status[1:0]
//
// a miss into an empty table goes from idle straight to the miss state; otherwise
// the engine starts a search and visits the occupied slots one at a time, then
// takes the miss state on a miss; the one read port of the slot ram sets that pace
// reset clears state, fill count, out valid; slots are never read before written
// a busy result register stalls the engine just before its write-back; a new
// item is taken while the previous result still waits downstream

module source_address_packet_counter
  import sapc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // source_address[31:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // entry_index[6:0], packet_count[38:7], pad
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  logic    start;
  logic    eng_ready;
  logic    out_free;
  logic    res_valid;
  result_t res;

  logic    out_valid_q, out_valid_d;
  result_t out_q;

  // item accepted on the input side
  assign s_axis_tready = eng_ready;
  assign start         = s_axis_tvalid && eng_ready;

  // result register can take a new result this cycle
  assign out_free = !out_valid_q || m_axis_tready;

  sapc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .addr_i      (s_axis_tdata),
    .ready_o     (eng_ready),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload only loads on a new result
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.packet_count, out_q.entry_index};
  assign m_axis_tuser  = out_q.status;

endmodule
